// File: rtl/cacc_pkg.sv
// ----------------------------------------------------------------------------
// cacc_pkg
// Shared types and constants of the single-slot consensus acceptor.
// ----------------------------------------------------------------------------
package cacc_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] NODES_RESET = CFG_W'(8);
    localparam logic [CFG_W-1:0] NODES_MAX   = CFG_W'(MAX_NODES);

    localparam logic [1:0] ACT_PROPOSAL = 2'd0;
    localparam logic [1:0] ACT_SET      = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT  = 2'd2;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_SET      = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] sender;
        logic [DATA_W-1:0] ticket_in;
        logic [DATA_W-1:0] slot_in;
        logic [DATA_W-1:0] value_in;
    } t_in_word;

    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [1:0]        kind_out;
        logic [DATA_W-1:0] ticket_out;
        logic [DATA_W-1:0] slot_out;
        logic [DATA_W-1:0] value_out;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic eq;
        logic lt;
        logic gt;
    } t_cmp_res;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SLOT  = 6'b000010,
        S_TICK  = 6'b000100,
        S_DEC   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_BCAST = 6'b100000
    } t_state;

endpackage

// File: rtl/cacc_cmp.sv
// ----------------------------------------------------------------------------
// cacc_cmp
// Shared 32-bit unsigned magnitude comparator with a registered result.
// ----------------------------------------------------------------------------
module cacc_cmp import cacc_pkg::*; (
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_cmp_res          o_res
);

    t_cmp_res r_res;

    always_ff @(posedge i_clk) begin
        r_res.eq <= (i_a == i_b);
        r_res.lt <= (i_a < i_b);
        r_res.gt <= (i_a > i_b);
    end

    assign o_res = r_res;

endmodule

// File: rtl/cacc_obuf.sv
// ----------------------------------------------------------------------------
// cacc_obuf
// One-word output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module cacc_obuf import cacc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/consensus_acceptor.sv
// ----------------------------------------------------------------------------
// consensus_acceptor
// Single-slot consensus acceptor: adopts, accepts or rejects proposals and
// broadcasts set words to all active nodes on a valid set request.
//
//   channel   signals                      dir
//   input     i_valid / o_ready / i_in     in
//   result    o_valid / i_ready / o_out    out
//   config    i_cfg_we / i_cfg_wdata       in
//
// an input word passes through the shared comparator in S_SLOT, S_TICK
// and S_DEC (slot, then ticket, then decision); result words go out in S_EMIT or S_BCAST
// a set broadcast issues nodes_clamp words, one per cycle while the
// output register drains
// result stalls hold the sequencer; o_ready is high only between words
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module consensus_acceptor import cacc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_in,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_word        o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_state            r_state, n_state;
    logic              r_phase, n_phase;
    logic [DATA_W-1:0] r_ticket, n_ticket;
    logic [DATA_W-1:0] r_value, n_value;
    logic [DATA_W-1:0] r_slot, n_slot;
    logic [NODE_W-1:0] r_leader, n_leader;
    logic [CFG_W-1:0]  r_nodes;
    t_in_word          r_item;
    logic              r_slot_eq, n_slot_eq;
    logic [NODE_W-1:0] r_dest, n_dest;
    logic [1:0]        r_kind, n_kind;
    logic [NODE_W-1:0] r_cnt, n_cnt;
    logic [NODE_W-1:0] r_cnt_last, n_cnt_last;

    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] cmp_b;
    t_cmp_res          cmp_res;
    logic              ob_load;
    logic              ob_free;
    t_out_word         ob_word;
    logic [CFG_W-1:0]  nodes_clamp;

    assign cmp_a = (r_state == S_SLOT) ? r_item.slot_in : r_item.ticket_in;
    assign cmp_b = (r_state == S_SLOT) ? r_slot : r_ticket;

    cacc_cmp u_cmp (
        .i_clk (i_clk),
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    cacc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (ob_load),
        .i_word  (ob_word),
        .o_free  (ob_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_word  (o_out)
    );

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        if (r_nodes == '0) begin
            nodes_clamp = CFG_W'(1);
        end else if (r_nodes > NODES_MAX) begin
            nodes_clamp = NODES_MAX;
        end else begin
            nodes_clamp = r_nodes;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_ticket   = r_ticket;
        n_value    = r_value;
        n_slot     = r_slot;
        n_leader   = r_leader;
        n_slot_eq  = r_slot_eq;
        n_dest     = r_dest;
        n_kind     = r_kind;
        n_cnt      = r_cnt;
        n_cnt_last = r_cnt_last;
        ob_load    = 1'b0;
        ob_word    = '0;
        ob_word.ticket_out = r_ticket;
        ob_word.slot_out   = r_slot;
        ob_word.value_out  = r_value;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_state = S_TICK;
            end
            S_TICK: begin
                n_slot_eq = cmp_res.eq;
                n_state   = S_DEC;
            end
            S_DEC: begin
                n_state = S_IDLE;
                if (!r_phase) begin
                    if (r_item.action == ACT_PROPOSAL) begin
                        n_ticket = r_item.ticket_in;
                        n_value  = r_item.value_in;
                        n_slot   = r_item.slot_in;
                        n_leader = r_item.sender;
                        n_phase  = 1'b1;
                        n_dest   = r_item.sender;
                        n_kind   = KIND_ACCEPTED;
                        n_state  = S_EMIT;
                    end
                end else if (r_item.action == ACT_TIMEOUT) begin
                    n_phase  = 1'b0;
                    n_ticket = '0;
                    n_value  = '0;
                    n_slot   = '0;
                    n_leader = '0;
                end else if (r_slot_eq) begin
                    if (r_item.action == ACT_PROPOSAL) begin
                        n_dest  = r_item.sender;
                        n_state = S_EMIT;
                        if (cmp_res.gt) begin
                            n_ticket = r_item.ticket_in;
                            n_value  = r_item.value_in;
                            n_leader = r_item.sender;
                            n_kind   = KIND_ACCEPTED;
                        end else begin
                            n_kind   = KIND_REJECTED;
                        end
                    end else if (r_item.action == ACT_SET) begin
                        if (!cmp_res.lt && r_item.sender == r_leader) begin
                            n_cnt      = '0;
                            n_cnt_last = NODE_W'(nodes_clamp - CFG_W'(1));
                            n_state    = S_BCAST;
                        end
                    end
                end
            end
            S_EMIT: begin
                ob_word.dest     = r_dest;
                ob_word.kind_out = r_kind;
                ob_word.last     = 1'b1;
                if (ob_free) begin
                    ob_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BCAST: begin
                ob_word.dest     = r_cnt;
                ob_word.kind_out = KIND_SET;
                ob_word.last     = (r_cnt == r_cnt_last);
                if (ob_free) begin
                    ob_load = 1'b1;
                    n_cnt   = r_cnt + NODE_W'(1);
                    if (r_cnt == r_cnt_last) begin
                        n_phase  = 1'b0;
                        n_ticket = '0;
                        n_value  = '0;
                        n_slot   = '0;
                        n_leader = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the slot compare result, registered by cacc_cmp from S_SLOT, is read in S_TICK
    always_ff @(posedge i_clk) begin
        r_slot_eq <= n_slot_eq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= 1'b0;
            r_ticket <= '0;
            r_value  <= '0;
            r_slot   <= '0;
            r_leader <= '0;
            r_nodes  <= NODES_RESET;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ticket <= n_ticket;
            r_value  <= n_value;
            r_slot   <= n_slot;
            r_leader <= n_leader;
            if (i_cfg_we) begin
                r_nodes <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_in;
        end
        r_dest     <= n_dest;
        r_kind     <= n_kind;
        r_cnt      <= n_cnt;
        r_cnt_last <= n_cnt_last;
    end

endmodule
